/* hw/rtl/uv_sphere_vertex_generator_macros.svh */
// Assertion macros for the UV sphere vertex generator.
// No dependencies; included by modules that assert.
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UVS_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define UVS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define UVS_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define UVS_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

/* hw/rtl/uvs_pkg.sv */
// Package for the UV sphere vertex generator: constants, types, CORDIC table.
// No dependencies.
`default_nettype none
package uvs_pkg;
    localparam int MAX_RINGS_DEF     = 4096;
    localparam int MAX_SECTORS_DEF   = 4096;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int IDX_W = 12;
    localparam int CFG_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [33:0] PI32 = 34'd13493037704;
    localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
    localparam int SAT_Q15 = 32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0, REG_RING_COUNT = 2'd1,
        REG_RING_STEP = 2'd2, REG_SECTOR_STEP = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [15:0] normal_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic [IDX_W-1:0] ring_index;
        logic [IDX_W-1:0] sector_index;
    } grid_t;

    // arctangent of 2^-i in radians with 32 fraction bits
    function automatic logic signed [35:0] atan_entry(input int i);
        logic signed [35:0] t;
        case (i)
            0:  t = 36'sd3373259426;
            1:  t = 36'sd1991351318;
            2:  t = 36'sd1052175346;
            3:  t = 36'sd534100635;
            4:  t = 36'sd268086748;
            5:  t = 36'sd134174063;
            6:  t = 36'sd67103403;
            7:  t = 36'sd33553749;
            8:  t = 36'sd16777131;
            9:  t = 36'sd8388597;
            10: t = 36'sd4194303;
            11: t = 36'sd2097152;
            12: t = 36'sd1048576;
            13: t = 36'sd524288;
            14: t = 36'sd262144;
            15: t = 36'sd131072;
            16: t = 36'sd65536;
            17: t = 36'sd32768;
            18: t = 36'sd16384;
            19: t = 36'sd8192;
            20: t = 36'sd4096;
            21: t = 36'sd2048;
            22: t = 36'sd1024;
            23: t = 36'sd512;
            default: t = 36'sd0;
        endcase
        return t;
    endfunction

    function automatic logic signed [15:0] sat15(input logic signed [36:0] v);
        logic signed [15:0] r;
        if (v > 37'sd32767)
            r = 16'sd32767;
        else if (v < -37'sd32767)
            r = -16'sd32767;
        else
            r = v[15:0];
        return r;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/uvs_stream_if.sv */
// Valid/ready stream interface carrying one payload beat.
// Depends on nothing; payload type given as parameter.
`default_nettype none
interface uvs_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/uvs_cordic.sv */
// Pipelined rotation-mode CORDIC giving Q1.15 cosine and sine of a 17-bit turn.
// Depends on uvs_pkg. One stage per iteration, advancing under en.
`default_nettype none
module uvs_cordic
    import uvs_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic [16:0] ang,
    output logic signed [15:0] cos_q15,
    output logic signed [15:0] sin_q15
);
    logic signed [35:0] x_reg [STAGES+1];
    logic signed [35:0] y_reg [STAGES+1];
    logic signed [35:0] z_reg [STAGES+1];
    logic [1:0] quad_reg [STAGES+1];
    logic [49:0] zin_next;

    // quarter-turn residue to radians, Q.32
    assign zin_next = ({35'd0, ang[14:0]} * {16'd0, PI32} + 50'd32768) >> 16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= $signed(zin_next[35:0]);
            quad_reg[0] <= ang[16:15];
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[i+1] <= quad_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
            end
        end
    end

    // round to Q1.15 and fold quadrant
    logic signed [15:0] c, s;
    assign c = sat15(37'(x_reg[STAGES] + 36'sd16384) >>> 15);
    assign s = sat15(37'(y_reg[STAGES] + 36'sd16384) >>> 15);
    always_comb
    begin
        case (quad_reg[STAGES])
            2'd0:    begin cos_q15 = c;  sin_q15 = s;  end
            2'd1:    begin cos_q15 = -s; sin_q15 = c;  end
            2'd2:    begin cos_q15 = -c; sin_q15 = -s; end
            default: begin cos_q15 = s;  sin_q15 = -c; end
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/uv_sphere_vertex_generator.sv */
// Beats pass the multiply, saturate, CORDIC, normal and position registers in turn.
// Throughput: one vertex per cycle while the skid is empty; the whole pipeline advances together.
// A stall on the output holds every stage; a one-entry skid lets input run on.
// Reset (rst_n, async low) clears valid bits and restores register defaults.
// Depends on uvs_pkg, uvs_stream_if, uvs_cordic and the macros header.
`default_nettype none
`include "uv_sphere_vertex_generator_macros.svh"
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS     = MAX_RINGS_DEF,
    parameter int MAX_SECTORS   = MAX_SECTORS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    uvs_stream_if.sink   in_s,
    uvs_stream_if.source out_s,
    input  wire logic cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);
    localparam int LAT = CORDIC_STAGES + 6;
    localparam logic [IDX_W-1:0] R_MAX = IDX_W'(MAX_RINGS > 4096 ? 4095 : MAX_RINGS - 1);
    localparam logic [IDX_W-1:0] S_MAX = IDX_W'(MAX_SECTORS > 4096 ? 4095 : MAX_SECTORS - 1);

    logic [15:0] radius_reg;
    logic [12:0] ring_count_reg;
    logic [16:0] ring_step_reg, sector_step_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            ring_count_reg <= 13'd16;
            ring_step_reg <= 17'd4369;
            sector_step_reg <= 17'd4369;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RADIUS:      radius_reg <= cfg_data[15:0];
                REG_RING_COUNT:  ring_count_reg <= cfg_data[12:0];
                REG_RING_STEP:   ring_step_reg <= cfg_data;
                REG_SECTOR_STEP: sector_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output skid and pipeline enable
    vertex_t skid_reg, res;
    logic skid_vld_reg, pipe_vld_out, en;
    logic [LAT-1:0] vld_reg;
    assign pipe_vld_out = vld_reg[LAT-1];
    assign en = !skid_vld_reg;
    assign in_s.ready = en;
    assign out_s.valid = skid_vld_reg || pipe_vld_out;
    assign out_s.data = skid_vld_reg ? skid_reg : res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], in_s.valid};
            if (skid_vld_reg && out_s.ready)
                skid_vld_reg <= 1'b0;
            else if (!skid_vld_reg && pipe_vld_out && !out_s.ready)
                skid_vld_reg <= 1'b1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (!skid_vld_reg && pipe_vld_out && !out_s.ready)
            skid_reg <= res;
    end

    // stage 1: clamp indices, multiply by steps
    logic [IDX_W-1:0] r_c, s_c;
    assign r_c = (in_s.data.ring_index > R_MAX) ? R_MAX : in_s.data.ring_index;
    assign s_c = (in_s.data.sector_index > S_MAX) ? S_MAX : in_s.data.sector_index;
    logic [28:0] u_prod_reg, p_prod_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_prod_reg <= {17'd0, s_c} * {12'd0, sector_step_reg};
            p_prod_reg <= {17'd0, r_c} * {12'd0, ring_step_reg};
        end
    end

    // stage 2: saturate fractions
    logic [16:0] u_reg, p_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= (u_prod_reg > 29'(ONE_Q16)) ? ONE_Q16 : u_prod_reg[16:0];
            p_reg <= (p_prod_reg > 29'(ONE_Q16)) ? ONE_Q16 : p_prod_reg[16:0];
        end
    end

    // texture coordinates ride alongside the CORDIC
    logic [16:0] tu_reg [CORDIC_STAGES+1];
    logic [16:0] tv_reg [CORDIC_STAGES+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tu_reg[0] <= u_reg;
            tv_reg[0] <= ONE_Q16 - p_reg;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                tu_reg[i+1] <= tu_reg[i];
                tv_reg[i+1] <= tv_reg[i];
            end
        end
    end

    logic signed [15:0] ca, sa, cp, sp;
    uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
        .clk(clk), .en(en), .ang({u_reg[15:0], 1'b0}), .cos_q15(ca), .sin_q15(sa));
    uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pol (
        .clk(clk), .en(en), .ang(p_reg), .cos_q15(cp), .sin_q15(sp));

    // normal products
    logic signed [31:0] nx_prod_reg, nz_prod_reg;
    logic signed [15:0] ny_reg;
    logic [16:0] tu2_reg, tv2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_prod_reg <= 32'(ca) * 32'(sp);
            nz_prod_reg <= 32'(sa) * 32'(sp);
            ny_reg <= -cp;
            tu2_reg <= tu_reg[CORDIC_STAGES];
            tv2_reg <= tv_reg[CORDIC_STAGES];
        end
    end

    // normal rounding
    logic signed [15:0] nx_reg, nz_reg, ny2_reg;
    logic [16:0] tu3_reg, tv3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= sat15(37'(nx_prod_reg + 32'sd16384) >>> 15);
            nz_reg <= sat15(37'(nz_prod_reg + 32'sd16384) >>> 15);
            ny2_reg <= ny_reg;
            tu3_reg <= tu2_reg;
            tv3_reg <= tv2_reg;
        end
    end

    // positions
    logic signed [32:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] nx4_reg, ny4_reg, nz4_reg;
    logic [16:0] tu4_reg, tv4_reg;
    logic signed [16:0] rad_s;
    assign rad_s = $signed({1'b0, radius_reg});
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= 33'(nx_reg) * 33'(rad_s);
            py_reg <= 33'(ny2_reg) * 33'(rad_s);
            pz_reg <= 33'(nz_reg) * 33'(rad_s);
            nx4_reg <= nx_reg;
            ny4_reg <= ny2_reg;
            nz4_reg <= nz_reg;
            tu4_reg <= tu3_reg;
            tv4_reg <= tv3_reg;
        end
    end

    logic signed [32:0] pxr, pyr, pzr;
    assign pxr = (px_reg + 33'sd16384) >>> 15;
    assign pyr = (py_reg + 33'sd16384) >>> 15;
    assign pzr = (pz_reg + 33'sd16384) >>> 15;
    always_comb
    begin
        res.pos_x = pxr[16:0];
        res.pos_y = pyr[16:0];
        res.pos_z = pzr[16:0];
        res.normal_x = nx4_reg;
        res.normal_y = ny4_reg;
        res.normal_z = nz4_reg;
        res.tex_u = tu4_reg;
        res.tex_v = tv4_reg;
    end

    `UVS_ASSERT_NEXT(a_skid_hold, clk, rst_n, skid_vld_reg && !out_s.ready, skid_vld_reg && $stable(skid_reg), "skid beat lost")
    `UVS_ASSERT_IMPL(a_no_accept_skid, clk, rst_n, skid_vld_reg, !in_s.ready, "input taken while skid full")
    `UVS_ASSERT_IMPL(a_norm_range, clk, rst_n, out_s.valid, $signed(out_s.data.normal_x) != -16'sd32768 && $signed(out_s.data.normal_z) != -16'sd32768, "normal out of range")
endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for uv_sphere_vertex_generator: random and directed grid points.
// Depends on uvs_pkg, uvs_stream_if and uv_sphere_vertex_generator from the RTL; the vertex predictor is local.
`default_nettype none
module tb
    import uvs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT   = CORDIC_STAGES_DEF + 6;
    localparam int TIME_LIMIT = 400000;
    localparam int N_STAGES   = CORDIC_STAGES_DEF;
    localparam longint unsigned PI_Q32 = 64'd13493037704;
    localparam longint GAIN_Q2_30 = 652032874;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    uvs_stream_if #(.payload_t(grid_t))   in_s ();
    uvs_stream_if #(.payload_t(vertex_t)) out_s ();

    uv_sphere_vertex_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_s      (in_s),
        .out_s     (out_s),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // local copy of the registers and arctangent table
    logic [15:0] sph_radius;
    logic [12:0] sph_rings;
    logic [16:0] sph_ring_step;
    logic [16:0] sph_sector_step;
    longint atan_q32 [N_STAGES];

    grid_t   pending_points [$];
    vertex_t expected_vertices [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_mismatch = 0;
    int n_cycles = 0;

    function automatic void build_atan();
        longint unsigned acc;
        longint unsigned term;
        int e;
        atan_q32[0] = 64'sd3373259426;
        for (int i = 1; i < N_STAGES; i++)
        begin
            acc = 0;
            for (int k = 0; k < 64; k++)
            begin
                e = 48 - i * (2 * k + 1);
                if (e < 0)
                    break;
                term = (64'd1 << e) / longint'(2 * k + 1);
                if (term == 0)
                    break;
                if (k % 2)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            atan_q32[i] = longint'((acc + 64'd32768) >> 16);
        end
    endfunction

    function automatic longint clip15(longint v);
        if (v > SAT_Q15)
            return SAT_Q15;
        if (v < -SAT_Q15)
            return -SAT_Q15;
        return v;
    endfunction

    // cosine and sine in Q1.15 of an angle in turns with 17 fraction bits
    function automatic void cordic_sincos(logic [16:0] ang, output longint co,
                                          output longint si);
        longint x, y, z, dx, dy, c, s;
        longint unsigned res;
        x = GAIN_Q2_30;
        y = 0;
        res = ang[14:0];
        z = longint'((res * PI_Q32 + 64'd32768) >> 16);
        for (int i = 0; i < N_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_q32[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_q32[i];
            end
        end
        c = clip15((x + 16384) >>> 15);
        s = clip15((y + 16384) >>> 15);
        case (ang[16:15])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    function automatic vertex_t sphere_vertex(grid_t g);
        vertex_t v;
        longint unsigned u, p;
        longint ca, sa, cp, sp;
        longint nrm [3];
        longint pv [3];
        logic [16:0] az;
        u = longint'(g.sector_index) * sph_sector_step;
        p = longint'(g.ring_index) * sph_ring_step;
        if (u > 65536)
            u = 65536;
        if (p > 65536)
            p = 65536;
        az = 17'(u << 1);
        cordic_sincos(az, ca, sa);
        cordic_sincos(17'(p), cp, sp);
        nrm[0] = clip15((ca * sp + 16384) >>> 15);
        nrm[1] = -cp;
        nrm[2] = clip15((sa * sp + 16384) >>> 15);
        for (int j = 0; j < 3; j++)
            pv[j] = (nrm[j] * longint'(sph_radius) + 16384) >>> 15;
        v.pos_x    = 17'(pv[0]);
        v.pos_y    = 17'(pv[1]);
        v.pos_z    = 17'(pv[2]);
        v.normal_x = 16'(nrm[0]);
        v.normal_y = 16'(nrm[1]);
        v.normal_z = 16'(nrm[2]);
        v.tex_u    = 17'(u);
        v.tex_v    = 17'(65536 - p);
        return v;
    endfunction

    // input driver: advances on accepted beats, idles at random
    always @(posedge clk)
    begin
        logic take;
        take = !in_s.valid || in_s.ready;
        if (in_s.valid && in_s.ready)
            expected_vertices.push_back(sphere_vertex(in_s.data));
        if (rst_n && take)
        begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_s.data  <= pending_points.pop_front();
                in_s.valid <= 1'b1;
            end
            else
                in_s.valid <= 1'b0;
        end
    end

    // output monitor and sink back-pressure
    always @(posedge clk)
    begin
        vertex_t want;
        vertex_t got;
        if (out_s.valid && out_s.ready)
        begin
            got = out_s.data;
            if (expected_vertices.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected vertex beat %h", got);
            end
            else
            begin
                want = expected_vertices.pop_front();
                check_field("pos_x", want.pos_x, got.pos_x);
                check_field("pos_y", want.pos_y, got.pos_y);
                check_field("pos_z", want.pos_z, got.pos_z);
                check_field("normal_x", 17'(want.normal_x), 17'(got.normal_x));
                check_field("normal_y", 17'(want.normal_y), 17'(got.normal_y));
                check_field("normal_z", 17'(want.normal_z), 17'(got.normal_z));
                check_field("tex_u", want.tex_u, got.tex_u);
                check_field("tex_v", want.tex_v, got.tex_v);
            end
        end
        out_s.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
        if (want !== got)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("%s mismatch: expected %h, got %h", name, want, got);
        end
    endtask

    // watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > TIME_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS:      sph_radius = value[15:0];
            REG_RING_COUNT:  sph_rings = value[12:0];
            REG_RING_STEP:   sph_ring_step = value;
            default:         sph_sector_step = value;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_points.size() > 0 || in_s.valid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic add_point(int r, int s);
        grid_t g;
        g.ring_index   = r[IDX_W-1:0];
        g.sector_index = s[IDX_W-1:0];
        pending_points.push_back(g);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(3) == 0)
                add_point($urandom_range(16), $urandom_range(16));
            else
                add_point($urandom_range(4095), $urandom_range(4095));
    endtask

    task automatic set_grid(logic [CFG_W-1:0] rad, logic [CFG_W-1:0] rings,
                            logic [CFG_W-1:0] rstep, logic [CFG_W-1:0] sstep);
        wait_drained();
        write_reg(REG_RADIUS, rad);
        write_reg(REG_RING_COUNT, rings);
        write_reg(REG_RING_STEP, rstep);
        write_reg(REG_SECTOR_STEP, sstep);
    endtask

    initial
    begin
        in_s.valid = 1'b0;
        in_s.data  = '0;
        out_s.ready = 1'b0;
        sph_radius = 16'd256;
        sph_rings = 13'd16;
        sph_ring_step = 17'd4369;
        sph_sector_step = 17'd4369;
        build_atan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed points at reset settings: poles, quadrants, clamped fractions
        for (int s = 0; s <= 16; s += 4)
            add_point(8, s);
        add_point(0, 0);
        add_point(15, 15);
        add_point(16, 16);
        add_point(4095, 4095);
        add_point(4095, 0);
        add_point(0, 4095);
        add_point(2730, 1365);
        add_point(4, 2);
        add_random(60);

        // largest radius, full-turn steps: fractions saturate at once
        set_grid(17'd65535, 17'd4096, 17'd65536, 17'd65536);
        add_point(0, 0);
        add_point(1, 1);
        add_point(4095, 4095);
        add_random(50);

        // zero radius and zero steps; masked high register bits
        set_grid(17'h10000, 17'h1E000, 17'd0, 17'd0);
        add_random(40);

        // finest steps, radius with all bits set above the field
        set_grid(17'h1FFFF, 17'd2, 17'd1, 17'd1);
        add_point(4095, 4095);
        add_random(40);

        // sender mostly idle
        send_idle_pct = 87;
        set_grid(17'd256, 17'd16, 17'd4369, 17'd4369);
        add_random(60);

        // receiver mostly stalling
        send_idle_pct = 0;
        recv_stall_pct = 87;
        set_grid(17'(($urandom_range(65535))), 17'd64, 17'd1040, 17'd1040);
        add_random(60);

        // both sides throttled lightly
        send_idle_pct = 9;
        recv_stall_pct = 9;
        set_grid(17'(($urandom_range(65535))), 17'd129, 17'd512, 17'd512);
        add_random(60);

        // sender holds off until the pipe is empty, then resumes
        set_grid(17'd128, 17'd33, 17'(($urandom_range(65535)) + 1),
                 17'(($urandom_range(65535)) + 1));
        add_random(40);
        while (pending_points.size() > 0 || in_s.valid || expected_vertices.size() > 0)
            @(posedge clk);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(60);

        wait_drained();
        if (n_mismatch == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
